>>> rtl/core/edfsp_pkg.sv
// ----------------------------------------------------------------------------
// edfsp_pkg
// Shared types and constants for the EDF slice picker.
// ----------------------------------------------------------------------------
package edfsp_pkg;

    localparam int TIME_W  = 31;
    localparam int ID_W    = 16;
    localparam int SLICE_W = TIME_W + 1;

    // Release time that marks "no release pending"
    localparam logic [TIME_W-1:0] NO_RELEASE = TIME_W'(1000000);

    typedef enum logic [1:0] {
        FUNC_RUN     = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_DECIDE  = 2'd2,
        FUNC_UNUSED  = 2'd3
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [ID_W-1:0]   thread_id;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] rel_time;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] now;
    } item_t;

endpackage

>>> rtl/core/edfsp_in_stage.sv
// ----------------------------------------------------------------------------
// edfsp_in_stage
// Input register: captures one accepted item per cycle.
// ----------------------------------------------------------------------------
module edfsp_in_stage
    import edfsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  item_t item_in,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    item_t item_reg;

    // Track whether the register holds a fresh item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= accept;
        end
    end

    // Capture the item payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

>>> rtl/core/edfsp_core.sv
// ----------------------------------------------------------------------------
// edfsp_core
// Round state, entry compares and slice selection with the result register.
// ----------------------------------------------------------------------------
module edfsp_core
    import edfsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  item_t              item,
    output logic               done,
    output logic               idle,
    output logic [ID_W-1:0]    chosen_id,
    output logic [SLICE_W-1:0] slice
);

    // Round state
    logic              have_runner_reg, have_runner_next;
    logic [ID_W-1:0]   best_id_reg, best_id_next;
    logic [TIME_W-1:0] best_deadline_reg, best_deadline_next;
    logic [TIME_W-1:0] best_remaining_reg, best_remaining_next;
    logic [TIME_W-1:0] next_release_reg, next_release_next;
    logic [TIME_W-1:0] next_period_reg, next_period_next;

    // Result register
    logic               done_reg, done_next;
    logic               idle_reg, idle_next;
    logic [ID_W-1:0]    chosen_id_reg, chosen_id_next;
    logic [SLICE_W-1:0] slice_reg, slice_next;

    // Compare and slice terms
    logic               run_better;
    logic               rel_better;
    logic [SLICE_W-1:0] end_sum;
    logic [SLICE_W-1:0] rel_span;
    logic [SLICE_W-1:0] to_deadline;
    logic [SLICE_W-1:0] to_release;
    logic               late;
    logic [SLICE_W-1:0] busy_slice;

    // Entry compares against the kept winners
    assign run_better = !have_runner_reg
                     || (item.deadline < best_deadline_reg)
                     || ((item.deadline == best_deadline_reg)
                         && (item.thread_id < best_id_reg));
    assign rel_better = item.rel_time < next_release_reg;

    // Sums and differences one bit wider than the operands
    assign end_sum     = {1'b0, item.now} + {1'b0, best_remaining_reg};
    assign rel_span    = {1'b0, next_release_reg} + {1'b0, next_period_reg};
    assign to_deadline = {1'b0, best_deadline_reg} - {1'b0, item.now};
    assign to_release  = {1'b0, next_release_reg} - {1'b0, item.now};
    assign late        = end_sum > {1'b0, best_deadline_reg};

    // Pick the slice for a runnable thread
    always_comb
    begin
        if (late)
        begin
            busy_slice = to_deadline;
        end
        else if (next_release_reg == NO_RELEASE)
        begin
            busy_slice = {1'b0, best_remaining_reg};
        end
        else if (end_sum < {1'b0, next_release_reg})
        begin
            busy_slice = {1'b0, best_remaining_reg};
        end
        else if (rel_span > {1'b0, best_deadline_reg})
        begin
            busy_slice = {1'b0, best_remaining_reg};
        end
        else
        begin
            busy_slice = to_release;
        end
    end

    // Next state and result
    always_comb
    begin
        have_runner_next    = have_runner_reg;
        best_id_next        = best_id_reg;
        best_deadline_next  = best_deadline_reg;
        best_remaining_next = best_remaining_reg;
        next_release_next   = next_release_reg;
        next_period_next    = next_period_reg;
        done_next           = 1'b0;
        idle_next           = idle_reg;
        chosen_id_next      = chosen_id_reg;
        slice_next          = slice_reg;

        if (item_valid)
        begin
            case (item.func)
                FUNC_RUN:
                begin
                    if (run_better)
                    begin
                        have_runner_next    = 1'b1;
                        best_id_next        = item.thread_id;
                        best_deadline_next  = item.deadline;
                        best_remaining_next = item.remaining;
                    end
                end
                FUNC_RELEASE:
                begin
                    if (rel_better)
                    begin
                        next_release_next = item.rel_time;
                        next_period_next  = item.period;
                    end
                end
                FUNC_DECIDE:
                begin
                    done_next = 1'b1;
                    if (have_runner_reg)
                    begin
                        idle_next      = 1'b0;
                        chosen_id_next = best_id_reg;
                        slice_next     = busy_slice;
                    end
                    else
                    begin
                        idle_next      = 1'b1;
                        chosen_id_next = '0;
                        slice_next     = to_release;
                    end
                    // Clear the round
                    have_runner_next    = 1'b0;
                    best_id_next        = '0;
                    best_deadline_next  = '0;
                    best_remaining_next = '0;
                    next_release_next   = NO_RELEASE;
                    next_period_next    = '0;
                end
                default:
                begin
                    // Drop unused codes
                end
            endcase
        end
    end

    // Hold round state and the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_runner_reg    <= 1'b0;
            best_id_reg        <= '0;
            best_deadline_reg  <= '0;
            best_remaining_reg <= '0;
            next_release_reg   <= NO_RELEASE;
            next_period_reg    <= '0;
            done_reg           <= 1'b0;
        end
        else
        begin
            have_runner_reg    <= have_runner_next;
            best_id_reg        <= best_id_next;
            best_deadline_reg  <= best_deadline_next;
            best_remaining_reg <= best_remaining_next;
            next_release_reg   <= next_release_next;
            next_period_reg    <= next_period_next;
            done_reg           <= done_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        idle_reg      <= idle_next;
        chosen_id_reg <= chosen_id_next;
        slice_reg     <= slice_next;
    end

    assign done      = done_reg;
    assign idle      = idle_reg;
    assign chosen_id = chosen_id_reg;
    assign slice     = slice_reg;

    // The kept release never lies above the no-release mark
    a_release_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_release_reg <= NO_RELEASE)
        else $error("kept release above no-release mark");

    // A strobe follows only a decide item
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(item_valid && (item.func == FUNC_DECIDE)))
        else $error("result without decide item");

    // A decide item leaves the round cleared
    a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!have_runner_reg && (next_release_reg == NO_RELEASE)
                      && (best_id_reg == '0)))
        else $error("round state not cleared after decide");

    // An idle result carries id zero
    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && idle_reg) |-> (chosen_id_reg == '0))
        else $error("idle result with nonzero id");

    // Without a runner the kept id stays zero
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        !have_runner_reg |-> (best_id_reg == '0))
        else $error("kept id without a runner");

endmodule

>>> rtl/core/edf_slice_picker.sv
// ----------------------------------------------------------------------------
// edf_slice_picker
// Earliest-deadline-first thread picker with time slice for one round.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is always low.
// A decide item passes the input register, then compare/slice logic into the
// result register, which loads done and the result together.
// Each result is shown for one cycle; the receiver cannot stall.
// Reset clears the round state (no runner, no release pending) and the strobe.
module edf_slice_picker
    import edfsp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [ID_W-1:0]    thread_id,
    input  logic [TIME_W-1:0]  deadline,
    input  logic [TIME_W-1:0]  remaining,
    input  logic [TIME_W-1:0]  rel_time,
    input  logic [TIME_W-1:0]  period,
    input  logic [TIME_W-1:0]  now,
    output logic               done,
    output logic               idle,
    output logic [ID_W-1:0]    chosen_id,
    output logic signed [SLICE_W-1:0] slice
);

    item_t              item_in;
    item_t              item_q;
    logic               item_valid;
    logic               accept;
    logic [SLICE_W-1:0] slice_raw;

    // Never back-pressure the sender
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Bundle the payload
    always_comb
    begin
        item_in.func      = func_t'(func);
        item_in.thread_id = thread_id;
        item_in.deadline  = deadline;
        item_in.remaining = remaining;
        item_in.rel_time  = rel_time;
        item_in.period    = period;
        item_in.now       = now;
    end

    edfsp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item_in    (item_in),
        .item_valid (item_valid),
        .item_out   (item_q)
    );

    edfsp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item_q),
        .done       (done),
        .idle       (idle),
        .chosen_id  (chosen_id),
        .slice      (slice_raw)
    );

    assign slice = $signed(slice_raw);

endmodule

>>> sim/edf_slice_picker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_slice_picker_tb
// Self-checking testbench for the EDF slice picker. A short table of rounds
// hits the extremes, tie rules, ignored codes and every slice case. Random
// rounds of run and release entries, each closed by a decide item, follow.
// Every accepted item goes through a local model of the round state. Each
// result strobe is then checked field by field against the oldest pick
// still pending.
// ----------------------------------------------------------------------------
module edf_slice_picker_tb;
    import edfsp_pkg::*;

    localparam int     TARGET_ITEMS  = 750;
    localparam int     CALM_ITEMS    = 100;     // tail of the run without gaps
    localparam int     SETTLE_CYCLES = 10;
    localparam int     CYCLE_LIMIT   = 200000;
    localparam longint TIME_MAX      = 64'h7FFF_FFFF;

    typedef struct packed {
        logic               idle;
        logic [ID_W-1:0]    id;
        logic [SLICE_W-1:0] slice;
    } pick_t;

    typedef struct packed {
        item_t  it;
        logic   pinned;
        pick_t  want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         func;
    logic [ID_W-1:0]    thread_id;
    logic [TIME_W-1:0]  deadline;
    logic [TIME_W-1:0]  remaining;
    logic [TIME_W-1:0]  rel_time;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  now;
    logic               done;
    logic               idle;
    logic [ID_W-1:0]    chosen_id;
    logic signed [SLICE_W-1:0] slice;

    // expected result typed into the table, travels with the item
    logic               row_pinned;
    pick_t              row_want;

    // round state of the local model
    logic               have_runner;
    logic [ID_W-1:0]    best_id;
    logic [TIME_W-1:0]  best_deadline;
    logic [TIME_W-1:0]  best_remaining;
    logic [TIME_W-1:0]  next_release;
    logic [TIME_W-1:0]  next_release_period;

    pick_t  pending_picks[$];
    row_t   directed_rows[$];

    int     fail_count;
    int     items_sent;
    int     rounds_sent;
    int     picks_checked;
    int     idle_picks;
    int     ignored_items;
    int     cycle_count;
    logic   gaps_on;

    edf_slice_picker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .thread_id    (thread_id),
        .deadline     (deadline),
        .remaining    (remaining),
        .rel_time     (rel_time),
        .period       (period),
        .now          (now),
        .done         (done),
        .idle         (idle),
        .chosen_id    (chosen_id),
        .slice        (slice)
    );

    // Generate the clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drop the round state back to empty
    function automatic void clear_round();
        have_runner         = 1'b0;
        best_id             = '0;
        best_deadline       = '0;
        best_remaining      = '0;
        next_release        = NO_RELEASE;
        next_release_period = '0;
    endfunction

    // Advance the round state by one item; return 1 when a pick comes out
    function automatic logic pick_next(input item_t it, output pick_t res);
        logic [TIME_W:0] finish_at;
        logic [TIME_W:0] release_end;
        res = '0;
        pick_next = 1'b0;
        case (it.func)
            FUNC_RUN:
            begin
                if (!have_runner || it.deadline < best_deadline ||
                    (it.deadline == best_deadline && it.thread_id < best_id))
                begin
                    have_runner    = 1'b1;
                    best_id        = it.thread_id;
                    best_deadline  = it.deadline;
                    best_remaining = it.remaining;
                end
            end
            FUNC_RELEASE:
            begin
                if (it.rel_time < next_release)
                begin
                    next_release        = it.rel_time;
                    next_release_period = it.period;
                end
            end
            FUNC_DECIDE:
            begin
                finish_at   = {1'b0, it.now} + {1'b0, best_remaining};
                release_end = {1'b0, next_release} + {1'b0, next_release_period};
                if (!have_runner)
                begin
                    res.idle  = 1'b1;
                    res.slice = {1'b0, next_release} - {1'b0, it.now};
                end
                else
                begin
                    res.id = best_id;
                    if (finish_at > {1'b0, best_deadline})
                        res.slice = {1'b0, best_deadline} - {1'b0, it.now};
                    else if (next_release == NO_RELEASE ||
                             finish_at < {1'b0, next_release} ||
                             release_end > {1'b0, best_deadline})
                        res.slice = {1'b0, best_remaining};
                    else
                        res.slice = {1'b0, next_release} - {1'b0, it.now};
                end
                clear_round();
                pick_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // Check result strobes, then predict from the item accepted at this edge
    always @(posedge clk)
    begin
        pick_t want;
        pick_t res;
        item_t seen;
        if (rst_n && done)
        begin
            if (pending_picks.size() == 0)
            begin
                $display("%0t: result with none pending, expected nothing, %s",
                         $time, "got:");
                $display("    idle=%0b id=%0d slice=%0d", idle, chosen_id, slice);
                fail_count++;
            end
            else
            begin
                want = pending_picks.pop_front();
                picks_checked++;
                if (idle !== want.idle)
                begin
                    $display("%0t: idle mismatch, expected %0b, got %0b", $time, want.idle, idle);
                    fail_count++;
                end
                if (chosen_id !== want.id)
                begin
                    $display("%0t: chosen_id mismatch, expected %0d, got %0d",
                             $time, want.id, chosen_id);
                    fail_count++;
                end
                if (slice !== want.slice)
                begin
                    $display("%0t: slice mismatch, expected %0d, got %0d",
                             $time, $signed(want.slice), slice);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            seen.func      = func_t'(func);
            seen.thread_id = thread_id;
            seen.deadline  = deadline;
            seen.remaining = remaining;
            seen.rel_time  = rel_time;
            seen.period    = period;
            seen.now       = now;
            if (pick_next(seen, res))
            begin
                if (row_pinned)
                    res = row_want;
                if (res.idle)
                    idle_picks++;
                pending_picks.push_back(res);
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d picks pending", $time, pending_picks.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic row_t make_row(input func_t f, input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] dl, input logic [TIME_W-1:0] rem,
                                      input logic [TIME_W-1:0] rel, input logic [TIME_W-1:0] per,
                                      input logic [TIME_W-1:0] t_now, input logic pin,
                                      input logic w_idle, input logic [ID_W-1:0] w_id,
                                      input logic [SLICE_W-1:0] w_slice);
        row_t r;
        r.it.func      = f;
        r.it.thread_id = id;
        r.it.deadline  = dl;
        r.it.remaining = rem;
        r.it.rel_time  = rel;
        r.it.period    = per;
        r.it.now       = t_now;
        r.pinned       = pin;
        r.want.idle    = w_idle;
        r.want.id      = w_id;
        r.want.slice   = w_slice;
        return r;
    endfunction

    // Present one item and hold it until it is taken
    task automatic present(input item_t it, input logic pin, input pick_t want);
        start      <= 1'b1;
        func       <= it.func;
        thread_id  <= it.thread_id;
        deadline   <= it.deadline;
        remaining  <= it.remaining;
        rel_time   <= it.rel_time;
        period     <= it.period;
        now        <= it.now;
        row_pinned <= pin;
        row_want   <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (it.func == FUNC_UNUSED)
            ignored_items++;
        else
            items_sent++;
    endtask

    // Insert a random burst of idle cycles, except near the end
    task automatic maybe_gap();
        if (gaps_on && items_sent < TARGET_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14))
                @(posedge clk);
        end
    endtask

    // Hold off until every pending pick has come out
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_picks.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TIME_W-1:0] near(input longint base, input int span);
        longint v;
        if ($urandom_range(0, 9) == 0)
            return TIME_W'($urandom());
        v = base + longint'(int'($urandom_range(0, 2 * span))) - longint'(span);
        if (v < 0)
            v = 0;
        if (v > TIME_MAX)
            v = TIME_MAX;
        return TIME_W'(v);
    endfunction

    function automatic item_t noise_item(input func_t f);
        item_t it;
        it.func      = f;
        it.thread_id = ID_W'($urandom());
        it.deadline  = TIME_W'($urandom());
        it.remaining = TIME_W'($urandom());
        it.rel_time  = TIME_W'($urandom());
        it.period    = TIME_W'($urandom());
        it.now       = TIME_W'($urandom());
        return it;
    endfunction

    // One random round: run and release entries, at times an unused code, in random order, then decide
    task automatic random_round();
        item_t            batch[$];
        item_t            it;
        item_t            tmp;
        int               n_run;
        int               n_rel;
        int               j;
        int               k;
        logic [TIME_W-1:0] t_now;
        logic [TIME_W-1:0] shared_dl;
        pick_t            none;
        none  = '0;
        t_now = ($urandom_range(0, 9) == 0) ? TIME_W'($urandom())
                                            : TIME_W'($urandom_range(0, 1100000));
        n_run = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
        n_rel = $urandom_range(0, 3);
        shared_dl = near(longint'(t_now) + 1500, 2000);
        for (j = 0; j < n_run; j++)
        begin
            it = noise_item(FUNC_RUN);
            if ($urandom_range(0, 1) == 0)
                it.thread_id = ID_W'($urandom_range(0, 7));
            it.deadline  = ($urandom_range(0, 3) == 0) ? shared_dl
                                                       : near(longint'(t_now) + 1500, 2000);
            it.remaining = near(1200, 1200);
            batch.push_back(it);
        end
        for (j = 0; j < n_rel; j++)
        begin
            it = noise_item(FUNC_RELEASE);
            case ($urandom_range(0, 7))
                0:       it.rel_time = NO_RELEASE;
                1:       it.rel_time = TIME_W'(NO_RELEASE - 1);
                default: it.rel_time = near(longint'(t_now) + 2000, 2500);
            endcase
            it.period = near(1500, 1500);
            batch.push_back(it);
        end
        if ($urandom_range(0, 11) == 0)
            batch.push_back(noise_item(FUNC_UNUSED));
        // shuffle the entries
        for (j = batch.size() - 1; j > 0; j--)
        begin
            k = $urandom_range(0, j);
            tmp = batch[j];
            batch[j] = batch[k];
            batch[k] = tmp;
        end
        it = noise_item(FUNC_DECIDE);
        it.now = t_now;
        batch.push_back(it);
        gaps_on = ($urandom_range(0, 3) != 0);
        foreach (batch[j])
        begin
            maybe_gap();
            present(batch[j], 1'b0, none);
        end
        rounds_sent++;
    endtask

    initial
    begin
        logic drained_mid;
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        func         = FUNC_RUN;
        thread_id    = '0;
        deadline     = '0;
        remaining    = '0;
        rel_time     = '0;
        period       = '0;
        now          = '0;
        row_pinned   = 1'b0;
        row_want     = '0;
        fail_count   = 0;
        items_sent   = 0;
        rounds_sent  = 0;
        picks_checked = 0;
        idle_picks   = 0;
        ignored_items = 0;
        cycle_count  = 0;
        gaps_on      = 1'b1;
        drained_mid  = 1'b0;
        clear_round();

        // Directed rounds: extremes, tie rules, ignored code, each slice case
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 0,
                                         1, 1, 0, 32'd1000000));
        directed_rows.push_back(make_row(FUNC_RUN, 16'hFFFF, '1, '1, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 0,
                                         1, 0, 16'hFFFF, 32'd2147483647));
        directed_rows.push_back(make_row(FUNC_RUN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, '1,
                                         1, 0, 0, 32'h8000_0001));
        directed_rows.push_back(make_row(FUNC_RUN, 5, 100, 50, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RUN, 3, 100, 20, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RUN, 7, 200, 5, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 90, 0, 0, 0, 0));
        // late releases are never kept; the unused code must change nothing
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, NO_RELEASE, 5, 0,
                                         0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, '1, 7, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_UNUSED, '1, '1, '1, '1, '1, '1, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 10,
                                         1, 1, 0, 32'd999990));
        // first release wins a tie; slice cut at the next release
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, 500, 100, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, 500, 999, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RUN, 1, 1000, 600, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // released thread's next deadline lies past ours: full remaining
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, 300, 800, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RUN, 2, 1000, 400, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // runner finishes before the release
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, 900, 10, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RUN, 4, 2000, 100, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_RELEASE, 0, 0, 0, 0, '1, 0, 0, 0, 0, 0));
        directed_rows.push_back(make_row(FUNC_DECIDE, 0, 0, 0, 0, 0, '1,
                                         1, 1, 0, 32'h8000_0001));

        // Hold reset, then release it on an edge
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            maybe_gap();
            present(directed_rows[i].it, directed_rows[i].pinned, directed_rows[i].want);
        end
        drain();

        while (items_sent < TARGET_ITEMS)
        begin
            random_round();
            if (!drained_mid && items_sent >= TARGET_ITEMS / 2)
            begin
                drain();
                drained_mid = 1'b1;
            end
        end

        drain();
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Sent %0d items in %0d random rounds plus the directed table, %0d ignored.",
                 items_sent, rounds_sent, ignored_items);
        $display("Checked %0d picks, %0d of them idle; %0d mismatches.",
                 picks_checked, idle_picks, fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/edfsp_pkg.sv
rtl/core/edfsp_in_stage.sv
rtl/core/edfsp_core.sv
rtl/core/edf_slice_picker.sv
sim/edf_slice_picker_tb.sv
